[hdl/phone_panel_status_decoder_top_defines.svh]
// Assertion macros for the phone panel status decoder.
`ifndef PHONE_PANEL_STATUS_DECODER_TOP_DEFINES_SVH
`define PHONE_PANEL_STATUS_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PPSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PPSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ppsd_pkg.sv]
// Shared constants, types and lamp decode for the phone panel status decoder.
package ppsd_pkg;

	localparam int LINES    = 12;
	localparam int LINE_AW  = $clog2(LINES);
	localparam int LINE_NW  = 4;
	localparam int SLOTS    = 32;
	localparam int SLOT_AW  = 5;
	localparam int CODE_W   = 4;

	localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'hF;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ONAIR     = 3'd1;
	localparam logic [2:0] ST_HANDSET   = 3'd2;
	localparam logic [2:0] ST_ELSEWHERE = 3'd3;
	localparam logic [2:0] ST_SCRHOLD   = 3'd4;
	localparam logic [2:0] ST_HOLD      = 3'd5;
	localparam logic [2:0] ST_BUSIED    = 3'd6;
	localparam logic [2:0] ST_RINGING   = 3'd7;

	localparam logic [2:0] EV_LINE   = 3'd0;
	localparam logic [2:0] EV_SCREEN = 3'd1;
	localparam logic [2:0] EV_VIP    = 3'd2;
	localparam logic [2:0] EV_RECORD = 3'd3;

	localparam logic [2:0] LAMP_OFF      = 3'd0;
	localparam logic [2:0] LAMP_ONAIR    = 3'd1;
	localparam logic [2:0] LAMP_HANDSET  = 3'd2;
	localparam logic [2:0] LAMP_ELSE     = 3'd3;
	localparam logic [2:0] LAMP_NONE     = 3'd4;
	localparam logic [2:0] LAMP_SCRHOLD  = 3'd5;
	localparam logic [2:0] LAMP_HOLD     = 3'd6;
	localparam logic [2:0] LAMP_RINGING  = 3'd7;

	localparam logic [1:0] ROW_KEY0 = 2'd0;
	localparam logic [1:0] ROW_KEY1 = 2'd1;
	localparam logic [2:0] COL_SCREEN = 3'd3;
	localparam logic [2:0] COL_VIP    = 3'd4;
	localparam logic [2:0] COL_KEY1_MAX = 3'd2;
	localparam logic [LINE_NW-1:0] LINES_PER_ROW = 4'd6;

	typedef struct packed {
		logic [2:0]         event_kind;
		logic [LINE_NW-1:0] line_index;
		logic [2:0]         line_status;
		logic               on_main_bank;
		logic               handset_at_screener;
		logic               flag_value;
		logic               last;
	} result_t;

	function automatic logic [2:0] lamp_to_state(input logic [2:0] lamp, input logic busy);
		logic [2:0] s;
		case (lamp)
			LAMP_OFF:     s = ST_IDLE;
			LAMP_ONAIR:   s = ST_ONAIR;
			LAMP_HANDSET: s = ST_HANDSET;
			LAMP_ELSE:    s = ST_ELSEWHERE;
			LAMP_SCRHOLD: s = ST_SCRHOLD;
			LAMP_HOLD:    s = busy ? ST_BUSIED : ST_HOLD;
			LAMP_RINGING: s = ST_RINGING;
			default:      s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

[hdl/ppsd_if.sv]
// Channel interfaces: panel items in, report items out, configuration writes.
interface ppsd_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] status_byte;

	modport source (output valid, output req_type, output status_byte, input ready);
	modport sink   (input valid, input req_type, input status_byte, output ready);
endinterface

interface ppsd_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_kind;
	logic [ppsd_pkg::LINE_NW-1:0]  line_index;
	logic [2:0]                    line_status;
	logic                          on_main_bank;
	logic                          handset_at_screener;
	logic                          flag_value;
	logic                          last;

	modport source (output valid, output event_kind, output line_index, output line_status,
		output on_main_bank, output handset_at_screener, output flag_value, output last,
		input ready);
	modport sink   (input valid, input event_kind, input line_index, input line_status,
		input on_main_bank, input handset_at_screener, input flag_value, input last,
		output ready);
endinterface

interface ppsd_cfg_if;
	logic valid;
	logic ready;
	logic busy_out_mode;

	modport source (output valid, output busy_out_mode, input ready);
	modport sink   (input valid, input busy_out_mode, output ready);
endinterface

[hdl/ppsd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ppsd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/phone_panel_status_decoder_top.sv]
// Phone panel status decoder top level: slot and line state stores with lookup FSM.
//
//  channel  | modport | item contents
//  ---------+---------+-----------------------------------------------------------
//  panel    | sink    | req_type, status_byte
//  report   | source  | event_kind, line_index, line_status, flags, last
//  cfg      | sink    | busy_out_mode (always ready)
//
// Status byte: accepted in idle, then looked up against the registered RAM read.
// Refresh: one line state RAM read per reported line.
// A full report register stalls the lookup or refresh walk; state holds until it drains.
// Reset clears per-entry valid bits of both stores at once; no clearing pass.
`include "phone_panel_status_decoder_top_defines.svh"

module phone_panel_status_decoder_top (
	input  logic   clk,
	input  logic   arst_n,
	ppsd_in_if.sink     panel,
	ppsd_out_if.source  report,
	ppsd_cfg_if.sink    cfg
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_REFR = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic                               busy_q;
	logic [7:0]                         byte_q;
	logic [ppsd_pkg::LINE_NW-1:0]       line_q;
	logic [ppsd_pkg::LINE_AW-1:0]       laddr_q, laddr_d;
	logic [ppsd_pkg::SLOT_AW-1:0]       saddr_d;
	logic [ppsd_pkg::SLOTS-1:0]         svld_q;
	logic [ppsd_pkg::LINES-1:0]         lvld_q;
	logic [ppsd_pkg::CODE_W-1:0]        srdata;
	logic [2:0]                         lrdata;
	ppsd_pkg::result_t                  out_q, out_d;
	logic                               out_valid_q;

	logic                               in_acc;
	logic                               can_push, push, done_look;
	logic                               slot_we, line_we;
	logic [2:0]                         col_in;
	logic [1:0]                         row_in;
	logic [ppsd_pkg::LINE_NW-1:0]       line_in;

	logic [ppsd_pkg::SLOT_AW-1:0]       slot;
	logic [2:0]                         led, col;
	logic [1:0]                         row;
	logic [ppsd_pkg::CODE_W-1:0]        stored;
	logic                               match, flag_hit, line_ok, line_chg, has_res;
	logic [2:0]                         flag_kind, ns, cur, rep;
	logic                               refr_last;

	assign cfg.ready   = 1'b1;
	assign panel.ready = (state_q == S_IDLE);
	assign in_acc      = panel.valid && panel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			busy_q <= cfg.busy_out_mode;
		end
	end

	// Line number of a line button: 6*(row-2)+col
	assign col_in  = panel.status_byte[7:5];
	assign row_in  = panel.status_byte[4:3];
	assign line_in = {1'b0, col_in} + (row_in[0] ? ppsd_pkg::LINES_PER_ROW : '0);

	// Decode of the held byte
	assign slot   = byte_q[7:3];
	assign led    = byte_q[2:0];
	assign row    = slot[1:0];
	assign col    = slot[4:2];
	assign stored = svld_q[slot] ? srdata : ppsd_pkg::CODE_UNKNOWN;
	assign match  = (stored == {1'b0, led});

	always_comb begin
		flag_hit  = 1'b0;
		flag_kind = ppsd_pkg::EV_SCREEN;
		if (row == ppsd_pkg::ROW_KEY0) begin
			if (col == ppsd_pkg::COL_SCREEN) begin
				flag_hit  = 1'b1;
				flag_kind = ppsd_pkg::EV_SCREEN;
			end else if (col == ppsd_pkg::COL_VIP) begin
				flag_hit  = 1'b1;
				flag_kind = ppsd_pkg::EV_VIP;
			end
		end else if (row == ppsd_pkg::ROW_KEY1 && col <= ppsd_pkg::COL_KEY1_MAX) begin
			flag_hit  = 1'b1;
			flag_kind = ppsd_pkg::EV_RECORD + col;
		end
	end

	assign cur      = lvld_q[laddr_q] ? lrdata : ppsd_pkg::ST_IDLE;
	assign ns       = ppsd_pkg::lamp_to_state(led, busy_q);
	assign line_ok  = row[1] && (line_q < ppsd_pkg::LINE_NW'(ppsd_pkg::LINES));
	assign line_chg = line_ok && (led != ppsd_pkg::LAMP_NONE) && (ns != cur);
	assign has_res  = !match && (flag_hit || line_chg);
	assign rep      = (cur == ppsd_pkg::ST_HOLD && busy_q) ? ppsd_pkg::ST_BUSIED : cur;
	assign refr_last = (laddr_q == ppsd_pkg::LINE_AW'(ppsd_pkg::LINES - 1));

	assign can_push  = !out_valid_q || report.ready;
	assign done_look = (state_q == S_LOOK) && (!has_res || can_push);
	assign push      = ((state_q == S_LOOK) && has_res && can_push)
	                || ((state_q == S_REFR) && can_push);
	assign slot_we   = done_look && !match;
	assign line_we   = done_look && !match && line_chg;

	always_comb begin
		out_d = '0;
		if (state_q == S_REFR) begin
			out_d.event_kind  = ppsd_pkg::EV_LINE;
			out_d.line_index  = ppsd_pkg::LINE_NW'(laddr_q);
			out_d.line_status = rep;
			out_d.last        = refr_last;
		end else if (flag_hit) begin
			out_d.event_kind  = flag_kind;
			out_d.flag_value  = (led != ppsd_pkg::LAMP_OFF);
			out_d.last        = 1'b1;
		end else begin
			out_d.event_kind  = ppsd_pkg::EV_LINE;
			out_d.line_index  = line_q;
			out_d.line_status = ns;
			out_d.last        = 1'b1;
		end
		out_d.on_main_bank        = (out_d.line_status == ppsd_pkg::ST_ONAIR);
		out_d.handset_at_screener = (out_d.line_status == ppsd_pkg::ST_HANDSET);
	end

	// Read addresses: taken from the input at accept, stepped on each refresh push, held otherwise
	always_comb begin
		saddr_d = slot;
		laddr_d = laddr_q;
		if (in_acc) begin
			saddr_d = panel.status_byte[7:3];
			if (panel.req_type) begin
				laddr_d = '0;
			end else if (line_in < ppsd_pkg::LINE_NW'(ppsd_pkg::LINES)) begin
				laddr_d = line_in[ppsd_pkg::LINE_AW-1:0];
			end else begin
				laddr_d = '0;
			end
		end else if (state_q == S_REFR && push && !refr_last) begin
			laddr_d = laddr_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = panel.req_type ? S_REFR : S_LOOK;
				end
			end
			S_LOOK: begin
				if (done_look) begin
					state_d = S_IDLE;
				end
			end
			S_REFR: begin
				if (push && refr_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			laddr_q     <= '0;
			svld_q      <= '0;
			lvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			laddr_q <= laddr_d;
			if (slot_we) begin
				svld_q[slot] <= 1'b1;
			end
			if (line_we) begin
				lvld_q[laddr_q] <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q <= panel.status_byte;
			line_q <= line_in;
		end
		if (push) begin
			out_q <= out_d;
		end
	end

	ppsd_ram #(
		.WIDTH(ppsd_pkg::CODE_W),
		.DEPTH(ppsd_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot),
		.wdata ({1'b0, led}),
		.raddr (saddr_d),
		.rdata (srdata)
	);

	ppsd_ram #(
		.WIDTH(3),
		.DEPTH(ppsd_pkg::LINES)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (laddr_q),
		.wdata (ns),
		.raddr (laddr_d),
		.rdata (lrdata)
	);

	assign report.valid               = out_valid_q;
	assign report.event_kind          = out_q.event_kind;
	assign report.line_index          = out_q.line_index;
	assign report.line_status         = out_q.line_status;
	assign report.on_main_bank        = out_q.on_main_bank;
	assign report.handset_at_screener = out_q.handset_at_screener;
	assign report.flag_value          = out_q.flag_value;
	assign report.last                = out_q.last;

	`PPSD_ASSERT_NXT(a_refr_start, in_acc && panel.req_type, state_q == S_REFR && laddr_q == '0, "refresh did not start at line zero")
	`PPSD_ASSERT_IMP(a_refr_last, push && state_q == S_REFR, out_d.last == refr_last, "refresh last flag misplaced")
	`PPSD_ASSERT_IMP(a_line_we_push, line_we, push, "line state written without a report")
	`PPSD_ASSERT_NXT(a_look_done, done_look, state_q == S_IDLE && !$past(in_acc), "lookup did not return to idle")

endmodule

[test/ppsd_report_checker.sv]
// Report checker for the phone panel status decoder: predicts report items and compares them.
module ppsd_report_checker (
	input  logic clk,
	input  logic arst_n,
	ppsd_in_if   panel,
	ppsd_out_if  report,
	ppsd_cfg_if  cfg,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ppsd_pkg::CODE_W-1:0] slot_code [ppsd_pkg::SLOTS];
	logic [2:0]                  line_state [ppsd_pkg::LINES];
	logic                        busy_mode;
	ppsd_pkg::result_t           report_q [$];
	ppsd_pkg::result_t           want;

	initial errors = 0;

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] exp_val);
		if (got !== exp_val)
			note_mismatch($sformatf("report %s got %0h expected %0h", name, got, exp_val));
	endtask

	task automatic queue_report(input ppsd_pkg::result_t r);
		report_q.insert(report_q.size(), r);
	endtask

	// hold shows as busied while lines are busied out
	function automatic logic [2:0] shown_status(input logic [2:0] st, input logic busy);
		return (st == ppsd_pkg::ST_HOLD && busy) ? ppsd_pkg::ST_BUSIED : st;
	endfunction

	function automatic ppsd_pkg::result_t make_report(input logic [2:0] kind,
		input logic [ppsd_pkg::LINE_NW-1:0] line, input logic [2:0] status, input logic flag,
		input logic is_last);
		ppsd_pkg::result_t r;
		r.event_kind          = kind;
		r.line_index          = line;
		r.line_status         = status;
		r.on_main_bank        = (status == ppsd_pkg::ST_ONAIR);
		r.handset_at_screener = (status == ppsd_pkg::ST_HANDSET);
		r.flag_value          = flag;
		r.last                = is_last;
		return r;
	endfunction

	task automatic predict_item(input logic req, input logic [7:0] b);
		logic [ppsd_pkg::SLOT_AW-1:0] slot;
		logic [2:0]                   lamp;
		logic [2:0]                   next_st;
		logic [1:0]                   row;
		logic [2:0]                   col;
		logic [ppsd_pkg::LINE_NW-1:0] line;
		if (req) begin
			for (int i = 0; i < ppsd_pkg::LINES; i++)
				queue_report(make_report(ppsd_pkg::EV_LINE, ppsd_pkg::LINE_NW'(i),
					shown_status(line_state[i], busy_mode), 1'b0, i == ppsd_pkg::LINES - 1));
			return;
		end
		slot = b[7:3];
		lamp = b[2:0];
		if (slot_code[slot] == {1'b0, lamp})
			return;
		slot_code[slot] = {1'b0, lamp};
		row = slot[1:0];
		col = slot[4:2];
		if (row == ppsd_pkg::ROW_KEY0) begin
			if (col == ppsd_pkg::COL_SCREEN)
				queue_report(make_report(ppsd_pkg::EV_SCREEN, '0, ppsd_pkg::ST_IDLE, |lamp, 1'b1));
			else if (col == ppsd_pkg::COL_VIP)
				queue_report(make_report(ppsd_pkg::EV_VIP, '0, ppsd_pkg::ST_IDLE, |lamp, 1'b1));
			return;
		end
		if (row == ppsd_pkg::ROW_KEY1) begin
			if (col <= ppsd_pkg::COL_KEY1_MAX)
				queue_report(make_report(ppsd_pkg::EV_RECORD + col, '0, ppsd_pkg::ST_IDLE, |lamp,
					1'b1));
			return;
		end
		line = (row[0] ? ppsd_pkg::LINES_PER_ROW : '0) + ppsd_pkg::LINE_NW'(col);
		if (line >= ppsd_pkg::LINES)
			return;
		case (lamp)
			ppsd_pkg::LAMP_OFF:     next_st = ppsd_pkg::ST_IDLE;
			ppsd_pkg::LAMP_ONAIR:   next_st = ppsd_pkg::ST_ONAIR;
			ppsd_pkg::LAMP_HANDSET: next_st = ppsd_pkg::ST_HANDSET;
			ppsd_pkg::LAMP_ELSE:    next_st = ppsd_pkg::ST_ELSEWHERE;
			ppsd_pkg::LAMP_SCRHOLD: next_st = ppsd_pkg::ST_SCRHOLD;
			ppsd_pkg::LAMP_HOLD:    next_st = busy_mode ? ppsd_pkg::ST_BUSIED : ppsd_pkg::ST_HOLD;
			ppsd_pkg::LAMP_RINGING: next_st = ppsd_pkg::ST_RINGING;
			default:                return;
		endcase
		if (line_state[line] == next_st)
			return;
		line_state[line] = next_st;
		queue_report(make_report(ppsd_pkg::EV_LINE, line, shown_status(next_st, busy_mode), 1'b0,
			1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppsd_pkg::SLOTS; i++)
				slot_code[i] = ppsd_pkg::CODE_UNKNOWN;
			for (int i = 0; i < ppsd_pkg::LINES; i++)
				line_state[i] = ppsd_pkg::ST_IDLE;
			busy_mode = 1'b0;
			report_q.delete();
			pending <= 0;
		end else begin
			if (report.valid && report.ready) begin
				if (report_q.size() == 0) begin
					note_mismatch("report item with nothing expected");
				end else begin
					want = report_q.pop_front();
					check_field("event_kind", 4'(report.event_kind), 4'(want.event_kind));
					check_field("line_index", report.line_index, want.line_index);
					check_field("line_status", 4'(report.line_status), 4'(want.line_status));
					check_field("on_main_bank", 4'(report.on_main_bank), 4'(want.on_main_bank));
					check_field("handset_at_screener", 4'(report.handset_at_screener),
						4'(want.handset_at_screener));
					check_field("flag_value", 4'(report.flag_value), 4'(want.flag_value));
					check_field("last", 4'(report.last), 4'(want.last));
				end
			end
			if (cfg.valid && cfg.ready)
				busy_mode = cfg.busy_out_mode;
			if (panel.valid && panel.ready)
				predict_item(panel.req_type, panel.status_byte);
			pending <= report_q.size();
		end
	end

endmodule

[test/phone_panel_status_decoder_top_test.sv]
// Testbench top for the phone panel status decoder: clock, reset, stimulus and verdict.
module phone_panel_status_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ROW_LINE_A = 2'd2;
	localparam logic [1:0] ROW_LINE_B = 2'd3;

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   errors;
	int   pending;

	ppsd_in_if  panel ();
	ppsd_out_if report ();
	ppsd_cfg_if cfg ();

	phone_panel_status_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.panel  (panel),
		.report (report),
		.cfg    (cfg)
	);

	ppsd_report_checker report_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.panel   (panel),
		.report  (report),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// report side stalls in bursts
	initial begin
		forever begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				report.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				report.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic logic [7:0] panel_byte(input logic [2:0] col, input logic [1:0] row,
		input logic [2:0] lamp);
		return {col, row, lamp};
	endfunction

	task automatic send_item(input logic req, input logic [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			panel.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		panel.valid       <= 1'b1;
		panel.req_type    <= req;
		panel.status_byte <= b;
		do @(posedge clk); while (!panel.ready);
	endtask

	task automatic send_status(input logic [2:0] col, input logic [1:0] row, input logic [2:0] lamp);
		send_item(1'b0, panel_byte(col, row, lamp));
	endtask

	task automatic wait_idle();
		panel.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (ppsd_pkg::LINES + 4) @(posedge clk);
	endtask

	task automatic write_busy(input logic mode);
		cfg.valid         <= 1'b1;
		cfg.busy_out_mode <= mode;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_random(input int count);
		logic [2:0] col;
		logic [1:0] row;
		repeat (count) begin
			case ($urandom_range(0, 19))
				0:       send_item(1'b1, 8'($urandom));
				1, 2:    send_item(1'b0, 8'($urandom));
				3, 4, 5, 6: begin
					case ($urandom_range(0, 4))
						0: begin
							col = ppsd_pkg::COL_SCREEN;
							row = ppsd_pkg::ROW_KEY0;
						end
						1: begin
							col = ppsd_pkg::COL_VIP;
							row = ppsd_pkg::ROW_KEY0;
						end
						default: begin
							col = 3'($urandom_range(0, ppsd_pkg::COL_KEY1_MAX));
							row = ppsd_pkg::ROW_KEY1;
						end
					endcase
					send_status(col, row, 3'($urandom));
				end
				default: begin
					row = $urandom_range(0, 1) ? ROW_LINE_B : ROW_LINE_A;
					col = 3'($urandom_range(0, 5));
					send_status(col, row, 3'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		idle_on           = 1'b1;
		panel.valid       <= 1'b0;
		panel.req_type    <= 1'b0;
		panel.status_byte <= '0;
		cfg.valid         <= 1'b0;
		cfg.busy_out_mode <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_busy(1'b0);
		send_item(1'b1, 8'h00);
		send_status(ppsd_pkg::COL_SCREEN, ppsd_pkg::ROW_KEY0, ppsd_pkg::LAMP_ONAIR);
		send_status(ppsd_pkg::COL_SCREEN, ppsd_pkg::ROW_KEY0, ppsd_pkg::LAMP_ONAIR); // repeat: no item
		send_status(ppsd_pkg::COL_VIP, ppsd_pkg::ROW_KEY0, ppsd_pkg::LAMP_RINGING);
		send_status(3'd0, ppsd_pkg::ROW_KEY1, ppsd_pkg::LAMP_OFF);
		send_status(3'd1, ppsd_pkg::ROW_KEY1, ppsd_pkg::LAMP_HOLD);
		send_status(ppsd_pkg::COL_KEY1_MAX, ppsd_pkg::ROW_KEY1, ppsd_pkg::LAMP_NONE);
		send_item(1'b0, 8'h00);                            // unused key slot
		send_status(3'd3, ppsd_pkg::ROW_KEY1, ppsd_pkg::LAMP_SCRHOLD);
		send_status(3'd0, ROW_LINE_A, ppsd_pkg::LAMP_OFF);          // already idle
		send_status(3'd0, ROW_LINE_A, ppsd_pkg::LAMP_ONAIR);
		send_status(3'd5, ROW_LINE_A, ppsd_pkg::LAMP_HANDSET);
		send_status(3'd0, ROW_LINE_B, ppsd_pkg::LAMP_ELSE);
		send_status(3'd5, ROW_LINE_B, ppsd_pkg::LAMP_SCRHOLD);
		send_status(3'd1, ROW_LINE_B, ppsd_pkg::LAMP_HOLD);
		send_status(3'd2, ROW_LINE_B, ppsd_pkg::LAMP_RINGING);
		send_status(3'd0, ROW_LINE_A, ppsd_pkg::LAMP_NONE);
		send_status(3'd0, ROW_LINE_A, ppsd_pkg::LAMP_ONAIR);        // state unchanged
		send_item(1'b0, 8'hFF);                            // line beyond range
		send_status(3'd6, ROW_LINE_B, ppsd_pkg::LAMP_ONAIR);
		send_item(1'b1, 8'hFF);
		wait_idle();

		write_busy(1'b1);
		send_item(1'b1, 8'h5A);
		send_status(3'd3, ROW_LINE_B, ppsd_pkg::LAMP_HOLD);
		send_status(3'd1, ROW_LINE_B, ppsd_pkg::LAMP_HOLD);
		send_item(1'b1, 8'hA5);
		wait_idle();

		send_random(120);
		wait_idle();
		write_busy(1'b0);
		send_random(120);
		wait_idle();
		write_busy(1'b1);
		send_random(80);
		wait_idle();
		write_busy(1'b0);

		idle_on = 1'b0;
		send_random(65);
		wait_idle();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
